FILE: sv/ftm_pkg.sv
package ftm_pkg;

  // Screen and map defaults
  localparam int unsigned ScreenWidthDef   = 640;
  localparam int unsigned ScreenHeightDef  = 480;
  localparam int unsigned HorizonOffsetDef = 250;
  localparam int unsigned MapSizeMaxDef    = 4096;

  // Field widths
  localparam int unsigned PIX_W  = 10;
  localparam int unsigned SIN_W  = 16;
  localparam int unsigned CAM_W  = 24;
  localparam int unsigned ZOOM_W = 16;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned TEX_W  = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Datapath widths
  localparam int unsigned XY_W    = 12;                  // signed X and Y
  localparam int unsigned PROD_W  = XY_W + SIN_W;        // one rotation product
  localparam int unsigned ROT_W   = PROD_W + 1;          // rotated coordinate
  localparam int unsigned N_W     = ROT_W + ZOOM_W + 1;  // scaled coordinate
  localparam int unsigned TRIG_FRAC = 14;
  localparam int unsigned MAG_W   = N_W - TRIG_FRAC;     // shifted numerator magnitude
  localparam int unsigned Z_W     = PIX_W;
  localparam int unsigned Q_W     = MAG_W + 1;           // signed floored quotient
  localparam int unsigned P_W     = Q_W + 1;             // signed Q8 map position
  localparam int unsigned POS_FRAC = 8;
  localparam int unsigned INT_W   = P_W - POS_FRAC;      // whole texels of |position|
  localparam int unsigned BND_W   = TEX_W + POS_FRAC;    // (size-1) in Q8

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SINE   = 3'd0,
    REG_COSINE = 3'd1,
    REG_CAM_X  = 3'd2,
    REG_CAM_Z  = 3'd3,
    REG_ZOOM   = 3'd4,
    REG_MAP_W  = 3'd5,
    REG_MAP_H  = 3'd6,
    REG_TILED  = 3'd7
  } cfg_idx_e;

  // Item leaving the projection front end
  typedef struct packed {
    logic             above;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [Z_W-1:0]   z;
  } front_t;

endpackage

FILE: sv/ftm_udiv.sv
module ftm_udiv #(
  parameter int unsigned DW  = 8,
  parameter int unsigned VW  = 8,
  parameter int unsigned SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [DW-1:0]  dividend_i,
  input  logic [VW-1:0]  divisor_i,
  input  logic [SBW-1:0] side_i,
  output logic           valid_o,
  output logic [DW-1:0]  quot_o,
  output logic [VW-1:0]  rem_o,
  output logic [SBW-1:0] side_o
);

  // One quotient bit per stage; the dividend shifts out as quotient bits shift in.
  logic           v_q   [DW];
  logic [VW-1:0]  rem_q [DW];
  logic [DW-1:0]  dq_q  [DW];
  logic [VW-1:0]  dv_q  [DW];
  logic [SBW-1:0] sb_q  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic           cv;
    logic [VW-1:0]  cr;
    logic [DW-1:0]  cd;
    logic [VW-1:0]  cdv;
    logic [SBW-1:0] cs;
    logic [VW:0]    trial;
    logic [VW:0]    diff;
    logic           ge;

    if (k == 0) begin : g_in
      assign cv  = valid_i;
      assign cr  = '0;
      assign cd  = dividend_i;
      assign cdv = divisor_i;
      assign cs  = side_i;
    end else begin : g_mid
      assign cv  = v_q[k-1];
      assign cr  = rem_q[k-1];
      assign cd  = dq_q[k-1];
      assign cdv = dv_q[k-1];
      assign cs  = sb_q[k-1];
    end

    assign trial = {cr, cd[DW-1]};
    assign diff  = trial - {1'b0, cdv};
    assign ge    = (trial >= {1'b0, cdv});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
      dq_q[k]  <= {cd[DW-2:0], ge};
      dv_q[k]  <= cdv;
      sb_q[k]  <= cs;
    end
  end

  assign valid_o = v_q[DW-1];
  assign quot_o  = dq_q[DW-1];
  assign rem_o   = rem_q[DW-1];
  assign side_o  = sb_q[DW-1];

endmodule

FILE: sv/ftm_front.sv
module ftm_front #(
  parameter int unsigned SCREEN_WIDTH   = ftm_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT  = ftm_pkg::ScreenHeightDef,
  parameter int unsigned HORIZON_OFFSET = ftm_pkg::HorizonOffsetDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [ftm_pkg::PIX_W-1:0]         pixel_x_i,
  input  logic [ftm_pkg::PIX_W-1:0]         pixel_y_i,
  input  logic signed [ftm_pkg::SIN_W-1:0]  sine_i,
  input  logic signed [ftm_pkg::SIN_W-1:0]  cosine_i,
  input  logic [ftm_pkg::ZOOM_W-1:0]        zoom_i,
  output logic                              valid_o,
  output ftm_pkg::front_t                   item_o
);

  localparam int unsigned XY_W   = ftm_pkg::XY_W;
  localparam int unsigned PROD_W = ftm_pkg::PROD_W;
  localparam int unsigned ROT_W  = ftm_pkg::ROT_W;
  localparam int unsigned N_W    = ftm_pkg::N_W;
  localparam int unsigned MAG_W  = ftm_pkg::MAG_W;
  localparam int unsigned Z_W    = ftm_pkg::Z_W;
  localparam int unsigned PIX_W  = ftm_pkg::PIX_W;
  localparam int unsigned HalfX  = SCREEN_WIDTH / 2;
  localparam int unsigned HalfY  = SCREEN_HEIGHT / 2;

  // Stage 0: screen offsets
  logic                     v0_q, above0_q, above0_d;
  logic signed [XY_W-1:0]   x0_q, x0_d, y0_q, y0_d;
  logic [Z_W-1:0]           z0_q, z0_d, zraw;

  assign x0_d     = $signed({{(XY_W-PIX_W){1'b0}}, pixel_x_i}) - $signed(XY_W'(HalfX));
  assign y0_d     = $signed({{(XY_W-PIX_W){1'b0}}, pixel_y_i} + XY_W'(HORIZON_OFFSET));
  assign above0_d = (pixel_y_i < PIX_W'(HalfY));
  assign zraw     = pixel_y_i - PIX_W'(HalfY);
  // Force a harmless divisor for zero depth and rows above the horizon
  assign z0_d     = (above0_d || zraw == '0) ? Z_W'(1) : zraw;

  // Stage 1: rotation products
  logic                     v1_q, above1_q;
  logic [Z_W-1:0]           z1_q;
  logic signed [PROD_W-1:0] xc1_q, xc1_d, ys1_q, ys1_d, xs1_q, xs1_d, yc1_q, yc1_d;

  assign xc1_d = x0_q * cosine_i;
  assign ys1_d = y0_q * sine_i;
  assign xs1_d = x0_q * sine_i;
  assign yc1_d = y0_q * cosine_i;

  // Stage 2: rotated coordinates
  logic                     v2_q, above2_q;
  logic [Z_W-1:0]           z2_q;
  logic signed [ROT_W-1:0]  rx2_q, rx2_d, ry2_q, ry2_d;

  assign rx2_d = ROT_W'(xc1_q) + ROT_W'(ys1_q);
  assign ry2_d = ROT_W'(yc1_q) - ROT_W'(xs1_q);

  // Stage 3: zoom
  logic                     v3_q, above3_q;
  logic [Z_W-1:0]           z3_q;
  logic signed [N_W-1:0]    nx3_q, nx3_d, ny3_q, ny3_d;
  logic signed [ftm_pkg::ZOOM_W:0] zoom_s;

  assign zoom_s = $signed({1'b0, zoom_i});
  assign nx3_d  = rx2_q * zoom_s;
  assign ny3_d  = ry2_q * zoom_s;

  // Stage 4: drop the Q.14 fraction (floor) and split sign from magnitude
  logic                     v4_q;
  ftm_pkg::front_t          item4_q, item4_d;
  logic signed [MAG_W-1:0]  sx, sy;

  assign sx = nx3_q[N_W-1:ftm_pkg::TRIG_FRAC];
  assign sy = ny3_q[N_W-1:ftm_pkg::TRIG_FRAC];

  always_comb begin
    item4_d.above = above3_q;
    item4_d.neg_x = sx[MAG_W-1];
    item4_d.neg_y = sy[MAG_W-1];
    item4_d.mag_x = sx[MAG_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
    item4_d.mag_y = sy[MAG_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
    item4_d.z     = z3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    z0_q     <= z0_d;
    above0_q <= above0_d;
    xc1_q    <= xc1_d;
    ys1_q    <= ys1_d;
    xs1_q    <= xs1_d;
    yc1_q    <= yc1_d;
    z1_q     <= z0_q;
    above1_q <= above0_q;
    rx2_q    <= rx2_d;
    ry2_q    <= ry2_d;
    z2_q     <= z1_q;
    above2_q <= above1_q;
    nx3_q    <= nx3_d;
    ny3_q    <= ny3_d;
    z3_q     <= z2_q;
    above3_q <= above2_q;
    item4_q  <= item4_d;
  end

  assign valid_o = v4_q;
  assign item_o  = item4_q;

endmodule

FILE: sv/ftm_wrap.sv
module ftm_wrap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic                              tag_i,
  input  logic                              neg_i,
  input  logic [ftm_pkg::MAG_W-1:0]         quot_i,
  input  logic [ftm_pkg::Z_W-1:0]           rem_i,
  input  logic signed [ftm_pkg::CAM_W-1:0]  cam_i,
  input  logic [ftm_pkg::TEX_W-1:0]         size_m1_i,
  input  logic                              tiled_i,
  output logic                              valid_o,
  output logic                              tag_o,
  output logic                              off_o,
  output logic [ftm_pkg::TEX_W-1:0]         texel_o
);

  localparam int unsigned Q_W   = ftm_pkg::Q_W;
  localparam int unsigned P_W   = ftm_pkg::P_W;
  localparam int unsigned INT_W = ftm_pkg::INT_W;
  localparam int unsigned TEX_W = ftm_pkg::TEX_W;
  localparam int unsigned FRAC  = ftm_pkg::POS_FRAC;
  localparam int unsigned BND_W = ftm_pkg::BND_W;
  localparam int unsigned SB_W  = TEX_W + 3;

  // Stage A: finish the floored division and add the camera
  logic                  va_q, taga_q;
  logic [Q_W-1:0]        qmag;
  logic signed [Q_W-1:0] qs;
  logic signed [P_W-1:0] pa_q, pa_d;

  assign qmag = Q_W'(quot_i) + Q_W'(neg_i && (rem_i != '0));
  assign qs   = neg_i ? $signed(-qmag) : $signed(qmag);
  assign pa_d = P_W'(qs) + P_W'(cam_i);

  // Stage B: bounds check and absolute value
  logic              offb, negp;
  logic [P_W-1:0]    absb;
  logic [BND_W-1:0]  bound;
  logic [SB_W-1:0]   side_d;

  assign bound  = {size_m1_i, {FRAC{1'b0}}};
  assign negp   = pa_q[P_W-1];
  assign offb   = !tiled_i && (negp || (pa_q > $signed(P_W'(bound))));
  assign absb   = negp ? P_W'(-pa_q) : P_W'(pa_q);
  assign side_d = {taga_q, offb, absb[FRAC-1], absb[FRAC +: TEX_W]};

  logic              vd;
  logic [INT_W-1:0]  qd_unused;
  logic [TEX_W-1:0]  remd;
  logic [SB_W-1:0]   side_q;

  // Remainder of whole texels by (size-1); the fraction rides alongside
  ftm_udiv #(
    .DW  (INT_W),
    .VW  (TEX_W),
    .SBW (SB_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (va_q),
    .dividend_i (absb[P_W-1:FRAC]),
    .divisor_i  (size_m1_i),
    .side_i     (side_d),
    .valid_o    (vd),
    .quot_o     (qd_unused),
    .rem_o      (remd),
    .side_o     (side_q)
  );

  // Stage C: pick wrapped or direct texel and round half up
  logic              vc_q, tagc_q, offc_q;
  logic [TEX_W-1:0]  texc_q, texc_d, whole;

  assign whole  = tiled_i ? remd : side_q[TEX_W-1:0];
  assign texc_d = whole + TEX_W'(side_q[TEX_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vc_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= pa_d;
    taga_q <= tag_i;
    texc_q <= texc_d;
    offc_q <= side_q[TEX_W+1];
    tagc_q <= side_q[TEX_W+2] | (|qd_unused & 1'b0);
  end

  assign valid_o = vc_q;
  assign tag_o   = tagc_q;
  assign off_o   = offc_q;
  assign texel_o = texc_q;

endmodule

FILE: sv/perspective_floor_texel_mapper_unit.sv
// Perspective floor texel mapper.
// Command channel: drive pixel_x_i/pixel_y_i with start high for one cycle to
// issue an item; busy is never raised, so a new item may be issued on every
// clock. Each item gives one result, shown for a single cycle with
// result_valid_o high. Results come out in issue order. The pipeline holds
// five projection stages, a 32-stage restoring divider by depth, one
// placement stage, a 26-stage divider that wraps whole texels by the map
// size minus one, rounding and the output register.
// Throughput is one item per clock.
// The receiver cannot stall: it must take each result in its strobe cycle.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write one register per clock.
// The user writes only while no item is in flight; the block does not enforce it.
// Reset clears the pipeline valid bits and loads the register defaults
// (heading 0, zoom 1.0, map 1024 by 1024, flat mode).
module perspective_floor_texel_mapper_unit #(
  parameter int unsigned SCREEN_WIDTH   = ftm_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT  = ftm_pkg::ScreenHeightDef,
  parameter int unsigned HORIZON_OFFSET = ftm_pkg::HorizonOffsetDef,
  parameter int unsigned MAP_SIZE_MAX   = ftm_pkg::MapSizeMaxDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [ftm_pkg::PIX_W-1:0]        pixel_x_i,
  input  logic [ftm_pkg::PIX_W-1:0]        pixel_y_i,
  input  logic                             cfg_we_i,
  input  logic [ftm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ftm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             result_valid_o,
  output logic [ftm_pkg::TEX_W-1:0]        texel_x_o,
  output logic [ftm_pkg::TEX_W-1:0]        texel_y_o,
  output logic                             outside_o
);

  localparam int unsigned SIN_W  = ftm_pkg::SIN_W;
  localparam int unsigned CAM_W  = ftm_pkg::CAM_W;
  localparam int unsigned ZOOM_W = ftm_pkg::ZOOM_W;
  localparam int unsigned SIZE_W = ftm_pkg::SIZE_W;
  localparam int unsigned TEX_W  = ftm_pkg::TEX_W;

  // Configuration registers
  logic signed [SIN_W-1:0] sine_q, cosine_q;
  logic signed [CAM_W-1:0] cam_x_q, cam_z_q;
  logic [ZOOM_W-1:0]       zoom_q;
  logic [SIZE_W-1:0]       map_w_q, map_h_q;
  logic                    tiled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_q   <= '0;
      cosine_q <= SIN_W'(16384);
      cam_x_q  <= '0;
      cam_z_q  <= '0;
      zoom_q   <= ZOOM_W'(256);
      map_w_q  <= SIZE_W'(1024);
      map_h_q  <= SIZE_W'(1024);
      tiled_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ftm_pkg::cfg_idx_e'(cfg_idx_i))
        ftm_pkg::REG_SINE:   sine_q   <= cfg_data_i[SIN_W-1:0];
        ftm_pkg::REG_COSINE: cosine_q <= cfg_data_i[SIN_W-1:0];
        ftm_pkg::REG_CAM_X:  cam_x_q  <= cfg_data_i[CAM_W-1:0];
        ftm_pkg::REG_CAM_Z:  cam_z_q  <= cfg_data_i[CAM_W-1:0];
        ftm_pkg::REG_ZOOM:   zoom_q   <= cfg_data_i[ZOOM_W-1:0];
        ftm_pkg::REG_MAP_W:  map_w_q  <= cfg_data_i[SIZE_W-1:0];
        ftm_pkg::REG_MAP_H:  map_h_q  <= cfg_data_i[SIZE_W-1:0];
        ftm_pkg::REG_TILED:  tiled_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Saturate map sizes and take size minus one
  logic [SIZE_W-1:0] w_c, h_c, w_m1, h_m1;

  assign w_c  = (map_w_q < SIZE_W'(2)) ? SIZE_W'(2) :
                (map_w_q > SIZE_W'(MAP_SIZE_MAX)) ? SIZE_W'(MAP_SIZE_MAX) : map_w_q;
  assign h_c  = (map_h_q < SIZE_W'(2)) ? SIZE_W'(2) :
                (map_h_q > SIZE_W'(MAP_SIZE_MAX)) ? SIZE_W'(MAP_SIZE_MAX) : map_h_q;
  assign w_m1 = w_c - SIZE_W'(1);
  assign h_m1 = h_c - SIZE_W'(1);

  assign busy = 1'b0;

  logic            fv;
  ftm_pkg::front_t fitem;

  ftm_front #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .HORIZON_OFFSET (HORIZON_OFFSET)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .sine_i    (sine_q),
    .cosine_i  (cosine_q),
    .zoom_i    (zoom_q),
    .valid_o   (fv),
    .item_o    (fitem)
  );

  // Divide both axes by depth
  logic                       dxv, dyv_unused;
  logic [ftm_pkg::MAG_W-1:0]  qx, qy;
  logic [ftm_pkg::Z_W-1:0]    rx, ry;
  logic [1:0]                 sbx;
  logic [0:0]                 sby;

  ftm_udiv #(
    .DW  (ftm_pkg::MAG_W),
    .VW  (ftm_pkg::Z_W),
    .SBW (2)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (fv),
    .dividend_i (fitem.mag_x),
    .divisor_i  (fitem.z),
    .side_i     ({fitem.above, fitem.neg_x}),
    .valid_o    (dxv),
    .quot_o     (qx),
    .rem_o      (rx),
    .side_o     (sbx)
  );

  ftm_udiv #(
    .DW  (ftm_pkg::MAG_W),
    .VW  (ftm_pkg::Z_W),
    .SBW (1)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (fv),
    .dividend_i (fitem.mag_y),
    .divisor_i  (fitem.z),
    .side_i     (fitem.neg_y),
    .valid_o    (dyv_unused),
    .quot_o     (qy),
    .rem_o      (ry),
    .side_o     (sby)
  );

  logic             wxv, wyv, above_w, tag_y, offx, offy;
  logic [TEX_W-1:0] tx, ty;

  ftm_wrap u_wrap_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dxv),
    .tag_i     (sbx[1]),
    .neg_i     (sbx[0]),
    .quot_i    (qx),
    .rem_i     (rx),
    .cam_i     (cam_x_q),
    .size_m1_i (w_m1[TEX_W-1:0]),
    .tiled_i   (tiled_q),
    .valid_o   (wxv),
    .tag_o     (above_w),
    .off_o     (offx),
    .texel_o   (tx)
  );

  // Both lanes share timing; the y lane valid tracks the x lane valid
  ftm_wrap u_wrap_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dyv_unused),
    .tag_i     (1'b0),
    .neg_i     (sby[0]),
    .quot_i    (qy),
    .rem_i     (ry),
    .cam_i     (cam_z_q),
    .size_m1_i (h_m1[TEX_W-1:0]),
    .tiled_i   (tiled_q),
    .valid_o   (wyv),
    .tag_o     (tag_y),
    .off_o     (offy),
    .texel_o   (ty)
  );

  // Output register: flip the row and blank off-map pixels and rows above the horizon
  logic             out_v_q;
  logic             out_off_q, out_off_d;
  logic [TEX_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  assign out_off_d = above_w | offx | offy | (tag_y & !wyv);
  assign out_x_d   = out_off_d ? '0 : tx;
  assign out_y_d   = out_off_d ? '0 : (h_m1[TEX_W-1:0] - ty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= wxv;
    end
  end

  always_ff @(posedge clk_i) begin
    out_off_q <= out_off_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
  end

  assign result_valid_o = out_v_q;
  assign texel_x_o      = out_x_q;
  assign texel_y_o      = out_y_q;
  assign outside_o      = out_off_q;

endmodule
